// ----- src/qfsg_pkg.sv -----
// Shared types and constants for the quick failure skip guard.
`timescale 1ns / 1ps

package qfsg_pkg;

    localparam int TIME_W   = 64;
    localparam int THRESH_W = 32;
    localparam int CHAIN_W  = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 80;

    localparam logic [THRESH_W-1:0] THRESH_RESET      = 32'd10000;
    localparam logic [CHAIN_W-1:0]  CHAIN_LIMIT_RESET = 8'd3;
    localparam logic [CHAIN_W-1:0]  CHAIN_MAX         = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WATCHED_THRESHOLD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHAIN_LIMIT       = 1'b1;

    typedef enum logic [1:0] {
        CMD_OPEN    = 2'd0,
        CMD_PLAYING = 2'd1,
        CMD_ENDED   = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_ADVANCE = 2'd0,
        ACT_HOLD    = 2'd1,
        ACT_QUIET   = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef struct packed {
        logic [TIME_W-1:0]  start_time;
        logic [CHAIN_W-1:0] fail_chain;
        logic               held_flag;
    } guard_state_t;

    typedef struct packed {
        action_t            action;
        logic [TIME_W-1:0]  played_ms;
        logic [CHAIN_W-1:0] chain_count;
    } guard_result_t;

endpackage

// ----- src/qfsg_step.sv -----
// Per-event update: start time, played time, failure chain and action.
`timescale 1ns / 1ps

module qfsg_step (
    input  qfsg_pkg::cmd_t                   cmd,
    input  logic [qfsg_pkg::TIME_W-1:0]      now_ms,
    input  qfsg_pkg::guard_state_t           state_cur,
    input  logic [qfsg_pkg::THRESH_W-1:0]    watched_threshold_ms,
    input  logic [qfsg_pkg::CHAIN_W-1:0]     chain_limit,
    output qfsg_pkg::guard_state_t           state_next,
    output qfsg_pkg::guard_result_t          result
);
    import qfsg_pkg::*;

    logic [TIME_W-1:0]  start_next;
    logic [TIME_W:0]    diff;
    logic [TIME_W-1:0]  elapsed;
    logic               watched;
    logic [CHAIN_W-1:0] chain_inc;

    // Update the start time; a play at time zero stores 1 since 0 means never played
    always_comb begin
        start_next = state_cur.start_time;
        unique case (cmd)
            CMD_OPEN: begin
                start_next = '0;
            end
            CMD_PLAYING: begin
                if (state_cur.start_time == '0) begin
                    start_next = (now_ms != '0) ? now_ms : TIME_W'(1);
                end
            end
            CMD_ENDED, CMD_QUERY: begin
                start_next = state_cur.start_time;
            end
        endcase
    end

    // Played time from the updated start; zero when never played or clock behind
    assign diff    = {1'b0, now_ms} - {1'b0, start_next};
    assign elapsed = ((start_next == '0) || diff[TIME_W]) ? '0 : diff[TIME_W-1:0];
    assign watched = (elapsed >= {{(TIME_W-THRESH_W){1'b0}}, watched_threshold_ms});

    assign chain_inc = (state_cur.fail_chain != CHAIN_MAX) ?
                       state_cur.fail_chain + CHAIN_W'(1) : CHAIN_MAX;

    // Chain, hold flag and action on an ended event
    always_comb begin
        state_next            = state_cur;
        state_next.start_time = start_next;
        result.action         = ACT_NONE;
        if (cmd == CMD_ENDED) begin
            if (watched) begin
                state_next.fail_chain = '0;
                state_next.held_flag  = 1'b0;
                result.action         = ACT_ADVANCE;
            end else begin
                state_next.fail_chain = chain_inc;
                if (chain_inc <= chain_limit) begin
                    result.action = ACT_ADVANCE;
                end else if (state_cur.held_flag) begin
                    result.action = ACT_QUIET;
                end else begin
                    state_next.held_flag = 1'b1;
                    result.action        = ACT_HOLD;
                end
            end
        end
        result.played_ms   = elapsed;
        result.chain_count = state_next.fail_chain;
    end

endmodule

// ----- src/quick_failure_skip_guard_core.sv -----
// Top level of the quick failure skip guard: handshake, registers and state.
//
// Usage:
//   The input channel (s_) carries one player event per transfer: the
//   command in s_tuser and the millisecond timestamp in s_tdata. The result
//   channel (m_) returns exactly one result per event: the action, the
//   played time and the quick failure count.
//   An event is captured in an input register, evaluated by the step logic
//   in the following cycle, and its result is held in an output register.
//   m_tvalid rises when the result is loaded into the output register;
//   throughput is one event per cycle while the receiver takes results,
//   since the guard state updates when the result register is loaded.
//   When the receiver stalls, the result waits in the output register and
//   one more event can be captured in the input register; s_tready then
//   drops until the result is taken.
//   The configuration port (cfg_we, cfg_addr, cfg_wdata) writes the watched
//   threshold (index 0) and the chain limit (index 1); write it only while
//   no event is in flight.
//   aresetn (synchronous, active low) empties both registers, clears the
//   start time, chain and hold flag, and restores threshold 10000 and
//   chain limit 3.
`timescale 1ns / 1ps

module quick_failure_skip_guard_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration writes
    input  logic                                cfg_we,
    input  logic [qfsg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [qfsg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Event input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [qfsg_pkg::S_TDATA_W-1:0]      s_tdata,   // [63:0] now_ms
    input  logic [1:0]                          s_tuser,   // [1:0] command
    // Result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] action, [65:2] played_ms, [73:66] chain_count, [79:74] zero
    output logic [qfsg_pkg::M_TDATA_W-1:0]      m_tdata
);
    import qfsg_pkg::*;

    logic [THRESH_W-1:0] thresh_reg;
    logic [CHAIN_W-1:0]  limit_reg;

    logic                in_valid_reg;
    cmd_t                in_cmd_reg;
    logic [TIME_W-1:0]   in_now_reg;

    logic                out_valid_reg;
    guard_result_t       out_result_reg;

    guard_state_t        state_reg;
    guard_state_t        state_next;
    guard_result_t       step_result;

    logic                advance;
    logic                in_load;

    // Move the captured event into the result register when it is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_load  = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
            limit_reg  <= CHAIN_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_WATCHED_THRESHOLD: thresh_reg <= cfg_wdata[THRESH_W-1:0];
                REG_CHAIN_LIMIT:       limit_reg  <= cfg_wdata[CHAIN_W-1:0];
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_cmd_reg <= cmd_t'(s_tuser);
            in_now_reg <= s_tdata;
        end
    end

    qfsg_step u_step (
        .cmd                  (in_cmd_reg),
        .now_ms               (in_now_reg),
        .state_cur            (state_reg),
        .watched_threshold_ms (thresh_reg),
        .chain_limit          (limit_reg),
        .state_next           (state_next),
        .result               (step_result)
    );

    // Guard state advances with each transfer into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_result_reg.chain_count, out_result_reg.played_ms,
                       out_result_reg.action};

    // Guard state only changes when an event is evaluated
    a_state_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("guard state changed without an event");

    // Reported chain count matches the stored chain
    a_chain_match: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_result_reg.chain_count == state_reg.fail_chain))
        else $error("result chain count differs from stored chain");

    // A hold answer leaves the hold flag set
    a_hold_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (step_result.action == ACT_HOLD)) |=> state_reg.held_flag)
        else $error("hold answered without setting the hold flag");

    // A playing event always leaves a nonzero start time
    a_playing_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_cmd_reg == CMD_PLAYING)) |=> (state_reg.start_time != '0))
        else $error("start time still zero after playing");

    // Only ended events produce an action other than none
    a_action_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_cmd_reg != CMD_ENDED)) |=> (out_result_reg.action == ACT_NONE))
        else $error("action reported for a non-ended event");

endmodule
